>>> hw/rtl/rwmf_pkg.sv
// Shared types and constants for the ring window median filter.
`default_nettype none
package rwmf_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TDATA_W  = 16;

  typedef struct packed {
    logic store;
    logic clear;
    logic rd_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic rd_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/rwmf_ctrl.sv
// Controller state machine that sequences stores and median queries.
`default_nettype none
module rwmf_ctrl
  import rwmf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_mode,
  output logic         in_ready,
  input  status_t      status,
  output cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_MED   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.clear  = 1'b1;
            state_next = ST_READ;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        if (status.rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_MED;
      end
      ST_MED: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rwmf_datapath.sv
// Sample ring, insertion sorter slots and median output register.
`default_nettype none
module rwmf_datapath
  import rwmf_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      median
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW - 1);

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]   ring_vld;
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_idx;
  logic [SAMPLE_W-1:0] rd_data;
  logic                ins_en;

  logic [SAMPLE_W-1:0] slot     [WINDOW];
  logic [SAMPLE_W-1:0] slot_next[WINDOW];
  logic [WINDOW-1:0]   slot_vld;
  logic [WINDOW-1:0]   slot_vld_next;
  logic [SAMPLE_W-1:0] med_value;

  assign status.rd_last  = (rd_idx == LAST_IDX);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring_mem[wr_ptr] <= sample;
    end
    if (cmd.rd_en) begin
      rd_data <= ring_vld[rd_idx] ? ring_mem[rd_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      wr_ptr   <= '0;
      rd_idx   <= '0;
      ins_en   <= 1'b0;
    end else begin
      ins_en <= cmd.rd_en;
      if (cmd.store) begin
        ring_vld[wr_ptr] <= 1'b1;
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd.clear) begin
        rd_idx <= '0;
      end else if (cmd.rd_en) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      end
    end
  end

  // Each slot either keeps its value, takes its left neighbor or takes the new sample.
  always_comb begin
    logic left_gt;
    logic self_gt;
    slot_next[0]     = slot[0];
    slot_vld_next[0] = slot_vld[0];
    if (!slot_vld[0] || (slot[0] > rd_data)) begin
      slot_next[0]     = rd_data;
      slot_vld_next[0] = 1'b1;
    end
    for (int j = 1; j < WINDOW; j++) begin
      left_gt = !slot_vld[j-1] || (slot[j-1] > rd_data);
      self_gt = !slot_vld[j] || (slot[j] > rd_data);
      slot_next[j]     = slot[j];
      slot_vld_next[j] = slot_vld[j];
      if (left_gt) begin
        slot_next[j]     = slot[j-1];
        slot_vld_next[j] = slot_vld[j-1];
      end else if (self_gt) begin
        slot_next[j]     = rd_data;
        slot_vld_next[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      for (int j = 0; j < WINDOW; j++) begin
        slot[j] <= slot_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
    end else if (cmd.clear) begin
      slot_vld <= '0;
    end else if (ins_en) begin
      slot_vld <= slot_vld_next;
    end
  end

  generate
    if ((WINDOW % 2) == 1) begin : g_odd
      assign med_value = slot[(WINDOW - 1) / 2];
    end else begin : g_even
      logic [SAMPLE_W:0] mid_sum;
      assign mid_sum   = {1'b0, slot[WINDOW / 2]} + {1'b0, slot[WINDOW / 2 - 1]};
      assign med_value = mid_sum[SAMPLE_W:1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      median <= med_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ring_window_median_filter_unit.sv
// Top level of the ring window median filter.
// A store keeps the controller idle, so the next transfer is accepted in the following cycle.
// A query reads the ring one entry per cycle into the insertion sorter, passes a drain state,
// then loads the median once the output is free and returns to idle for the next transfer.
// Synchronous reset clears the ring to zeros through per-entry valid bits, the write
// pointer and all handshake state; no clearing pass is needed.
`default_nettype none
module ring_window_median_filter_unit
  import rwmf_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,   // [9:0] sample, rest zero
  input  wire logic [0:0]         s_tuser,   // [0] mode
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [TDATA_W-1:0]      m_tdata    // [9:0] median, rest zero
);

  cmd_t                cmd;
  status_t             status;
  logic [SAMPLE_W-1:0] median;

  rwmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser[0]),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rwmf_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_tdata[SAMPLE_W-1:0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .median    (median)
  );

  assign m_tdata = {{(TDATA_W - SAMPLE_W){1'b0}}, median};

endmodule
`default_nettype wire

>>> tb/sv/rwmf_tb_pkg.sv
// Mode codes shared by the median filter testbench and its checker.
`timescale 1ns / 100ps
package rwmf_tb_pkg;

  typedef enum logic {
    MODE_STORE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

endpackage

>>> tb/sv/rwmf_median_checker.sv
// Checker that models the sample ring and compares every reported median.
`timescale 1ns / 100ps
module rwmf_median_checker
  import rwmf_pkg::*;
  import rwmf_tb_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,
  input  logic [0:0]         s_tuser,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  output int                 fail_count,
  output int                 medians_waiting,
  output int                 stores_seen,
  output int                 queries_seen,
  output int                 medians_checked
);

  logic [SAMPLE_W-1:0] sample_ring [WINDOW];
  int                  wr_ptr;
  logic [SAMPLE_W-1:0] median_queue [$];
  int                  fails = 0;
  int                  waiting = 0;
  int                  n_stores = 0;
  int                  n_queries = 0;
  int                  n_checked = 0;

  assign fail_count      = fails;
  assign medians_waiting = waiting;
  assign stores_seen     = n_stores;
  assign queries_seen    = n_queries;
  assign medians_checked = n_checked;

  function automatic logic [SAMPLE_W-1:0] ring_median();
    logic [SAMPLE_W-1:0] sorted [WINDOW];
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W:0]   pair_sum;
    int                  j;
    for (int i = 0; i < WINDOW; i++) sorted[i] = sample_ring[i];
    for (int i = 1; i < WINDOW; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (WINDOW % 2 == 1) return sorted[(WINDOW-1)/2];
    pair_sum = {1'b0, sorted[WINDOW/2]} + {1'b0, sorted[WINDOW/2-1]};
    return pair_sum[SAMPLE_W:1];
  endfunction

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) sample_ring[i] = '0;
      wr_ptr = 0;
      median_queue.delete();
      waiting = 0;
    end else begin
      // The result side is checked first, since a median can only belong to an earlier query.
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (median_queue.size() == 0) begin
          $display("%0t: median transfer 0x%0h with no query waiting", $time, m_tdata);
          fails++;
        end else begin
          want = median_queue.pop_front();
          waiting = median_queue.size();
          if (m_tdata !== {{(TDATA_W-SAMPLE_W){1'b0}}, want}) begin
            $display("%0t: median mismatch, expected 0x%0h, actual 0x%0h",
                     $time, want, m_tdata);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (mode_e'(s_tuser[0]) == MODE_QUERY) begin
          median_queue.push_back(ring_median());
          waiting = median_queue.size();
          n_queries++;
        end else begin
          sample_ring[wr_ptr] = s_tdata[SAMPLE_W-1:0];
          wr_ptr = (wr_ptr == WINDOW - 1) ? 0 : wr_ptr + 1;
          n_stores++;
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_ring_window_median_filter_unit.sv
// Testbench top for the ring window median filter: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_ring_window_median_filter_unit;
  import rwmf_pkg::*;
  import rwmf_tb_pkg::*;

  localparam int WINDOW      = 32;
  localparam int ITEMS       = 1400;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;

  logic               clk = 1'b0;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic [0:0]         s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;

  int fail_count;
  int medians_waiting;
  int stores_seen;
  int queries_seen;
  int medians_checked;
  int items_sent = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;
  int hold_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ring_window_median_filter_unit #(.WINDOW(WINDOW)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rwmf_median_checker #(.WINDOW(WINDOW)) i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .medians_waiting (medians_waiting),
    .stores_seen     (stores_seen),
    .queries_seen    (queries_seen),
    .medians_checked (medians_checked)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ring_window_median_filter_unit failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input mode_e mode, input logic [SAMPLE_W-1:0] sample);
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = {{(TDATA_W-SAMPLE_W){1'b0}}, sample};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    @(negedge clk);
    items_sent++;
  endtask

  task automatic idle_gap(input int cycles);
    s_tvalid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int theme);
    case (theme)
      1: return '1;
      2: return '0;
      3: begin
        case ($urandom_range(0, 5))
          0: return 10'd0;
          1: return 10'd1;
          2: return 10'd511;
          3: return 10'd512;
          4: return 10'd1022;
          default: return 10'd1023;
        endcase
      end
      4: return SAMPLE_W'($urandom_range(500, 520));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Receiver: a rotating ready pattern that is replaced now and then, plus one long hold-off.
  initial begin
    logic [15:0] ready_pattern;
    int          pat_pos;
    int          pat_left;
    m_tready = 1'b0;
    pat_pos  = 0;
    pat_left = 0;
    ready_pattern = '1;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready = 1'b0;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk);
          hold_count++;
        end
      end
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom) & 16'($urandom);
          default: ready_pattern = 16'($urandom) | 16'($urandom);
        endcase
        if (ready_pattern == '0) ready_pattern[0] = 1'b1;
        pat_left = $urandom_range(50, 400);
      end
      m_tready = ready_pattern[pat_pos];
      pat_pos  = (pat_pos + 1) % 16;
      pat_left--;
    end
  end

  initial begin
    int    burst_len;
    int    run_left;
    int    theme;
    mode_e mode;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty ring, ignored sample on a query, extremes and a partly filled ring.
    send_item(MODE_QUERY, 10'd0);
    send_item(MODE_QUERY, 10'd1023);
    send_item(MODE_STORE, 10'd1023);
    send_item(MODE_QUERY, 10'd0);
    send_item(MODE_STORE, 10'd0);
    send_item(MODE_STORE, 10'd1023);
    send_item(MODE_STORE, 10'd1);
    send_item(MODE_STORE, 10'd1022);
    send_item(MODE_STORE, 10'd512);
    send_item(MODE_STORE, 10'd511);
    send_item(MODE_QUERY, 10'd682);
    send_item(MODE_STORE, 10'd341);
    send_item(MODE_STORE, 10'd682);
    send_item(MODE_QUERY, 10'd341);
    idle_gap(3);

    // Random: runs of bursts sharing a value theme, so the ring fills with extremes at times.
    run_left = 0;
    theme    = 0;
    while (items_sent < ITEMS) begin
      if (run_left == 0) begin
        theme    = $urandom_range(0, 5);
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      burst_len = $urandom_range(1, 24);
      repeat (burst_len) begin
        mode = ($urandom_range(0, 3) == 0) ? MODE_QUERY : MODE_STORE;
        send_item(mode, (mode == MODE_QUERY) ? SAMPLE_W'($urandom) : pick_sample(theme));
        if (items_sent == ITEMS / 2) hold_request = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end

    s_tvalid = 1'b0;
    wait (medians_waiting == 0);
    repeat (WINDOW + 8) @(posedge clk);
    $display("Run covered %0d sample stores and %0d median queries, %0d medians compared,",
             stores_seen, queries_seen, medians_checked);
    $display("including an empty ring, extreme values and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb_ring_window_median_filter_unit passed");
    end else begin
      $display("tb_ring_window_median_filter_unit failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rwmf_pkg.sv
hw/rtl/rwmf_ctrl.sv
hw/rtl/rwmf_datapath.sv
hw/rtl/ring_window_median_filter_unit.sv
tb/sv/rwmf_tb_pkg.sv
tb/sv/rwmf_median_checker.sv
tb/sv/tb_ring_window_median_filter_unit.sv
